// File: sv/u8cpt_pkg.sv
// u8cpt_pkg: shared types and byte-class constants for the UTF-8 position tracker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package u8cpt_pkg;

   localparam logic [7:0] TRAIL_MASK  = 8'hC0;
   localparam logic [7:0] TRAIL_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_CODE  = 8'hF0;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_ONE  = 3'd1;

   // One classified byte on its way from the front to the back.
   typedef struct packed {
      logic [7:0] data;      // the byte itself
      logic [2:0] grp_len;   // 2..4 for a lead with all its trailers present, else 0
      logic       trailer;   // byte is 10xxxxxx
      logic       last;      // final byte of the stream
   } job_type;

endpackage

`default_nettype wire

// File: sv/u8cpt_front.sv
// u8cpt_front: accepts input words, keeps the three-byte lookahead window and
// classifies bytes into jobs; drains the window at end of stream. Uses u8cpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8cpt_front import u8cpt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_stream,
   output logic            push_valid,
   input  wire logic       push_ready,
   output job_type         push_job
);

   logic [7:0] win_ff [4];
   logic [7:0] win_in [4];
   logic [2:0] held_ff, held_in;
   logic       flush_ff, flush_in;
   logic       accept;
   logic       full_window;

   function automatic logic is_trailer(input logic [7:0] b);
      return (b & TRAIL_MASK) == TRAIL_CODE;
   endfunction

   // Classify b0 given up to three following bytes, avail of which exist.
   function automatic job_type classify(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2, input logic [7:0] b3,
                                        input logic [1:0] avail, input logic last);
      logic [2:0] len;
      logic       t1, t2, t3;
      logic       ok;
      job_type    j;
      len = LEN_NONE;
      if ((b0 & LEAD2_MASK) == LEAD2_CODE)      len = 3'd2;
      else if ((b0 & LEAD3_MASK) == LEAD3_CODE) len = 3'd3;
      else if ((b0 & LEAD4_MASK) == LEAD4_CODE) len = 3'd4;
      t1 = (avail >= 2'd1) && is_trailer(b1);
      t2 = (avail >= 2'd2) && is_trailer(b2);
      t3 = (avail == 2'd3) && is_trailer(b3);
      case (len)
         3'd2:    ok = t1;
         3'd3:    ok = t1 && t2;
         3'd4:    ok = t1 && t2 && t3;
         default: ok = 1'b0;
      endcase
      j.data    = b0;
      j.grp_len = ok ? len : LEN_NONE;
      j.trailer = is_trailer(b0);
      j.last    = last;
      return j;
   endfunction

   assign full_window = (held_ff == 3'd3);
   assign req_ready   = !flush_ff && (!full_window || req_end_of_stream || push_ready);
   assign accept      = req_valid && req_ready;

   always_comb begin
      // flush drains from the window; steady state classifies the oldest held byte
      if (flush_ff) begin
         push_valid = 1'b1;
         push_job   = classify(win_ff[0], win_ff[1], win_ff[2], win_ff[3],
                               2'(held_ff - 3'd1), held_ff == 3'd1);
      end else begin
         push_valid = req_valid && !req_end_of_stream && full_window;
         push_job   = classify(win_ff[0], win_ff[1], win_ff[2], req_data_byte,
                               2'd3, 1'b0);
      end
   end

   always_comb begin
      win_in   = win_ff;
      held_in  = held_ff;
      flush_in = flush_ff;
      if (flush_ff) begin
         if (push_ready) begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = win_ff[3];
            held_in   = held_ff - 3'd1;
            if (held_ff == 3'd1) flush_in = 1'b0;
         end
      end else if (accept) begin
         if (req_end_of_stream) begin
            win_in[held_ff[1:0]] = req_data_byte;
            held_in  = held_ff + 3'd1;
            flush_in = 1'b1;
         end else if (full_window) begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = req_data_byte;
         end else begin
            win_in[held_ff[1:0]] = req_data_byte;
            held_in = held_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 3'd0;
         flush_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

// File: sv/u8cpt_queue.sv
// u8cpt_queue: two-entry job queue between front and back.
// Uses job_type from u8cpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8cpt_queue import u8cpt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire job_type push_job,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output job_type      pop_job
);

   job_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// File: sv/u8cpt_back.sv
// u8cpt_back: applies jobs to the character counter and group state and
// drives the registered result word. Uses u8cpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8cpt_back import u8cpt_pkg::*; #(
   parameter int INDEX_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        pop_valid,
   output logic             pop_ready,
   input  wire job_type     pop_job,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic [31:0]      rsp_char_index,
   output logic             rsp_starts_char,
   output logic [2:0]       rsp_char_len,
   output logic             rsp_last
);

   localparam logic [INDEX_WIDTH-1:0] IDX_ONE = INDEX_WIDTH'(1);

   logic [31:0]            start_ff, start_in;
   logic [INDEX_WIDTH-1:0] counter_ff, counter_in, counter_now;
   logic [1:0]             trailers_left_ff, trailers_left_in, trailers_left_now;
   logic [2:0]             group_len_ff, group_len_in, group_len_now;
   logic                   take;
   logic                   starts_now;
   logic [2:0]             len_now;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             out_byte_ff;
   logic [31:0]            char_index_ff;
   logic                   starts_char_ff, last_ff;
   logic [2:0]             char_len_ff;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   // state after the popped byte is counted
   always_comb begin
      if (pop_job.grp_len != LEN_NONE) begin
         counter_now       = counter_ff + IDX_ONE;
         trailers_left_now = 2'(pop_job.grp_len - 3'd1);
         group_len_now     = pop_job.grp_len;
         starts_now        = 1'b1;
         len_now           = pop_job.grp_len;
      end else if (pop_job.trailer && trailers_left_ff != 2'd0) begin
         counter_now       = counter_ff;
         trailers_left_now = trailers_left_ff - 2'd1;
         group_len_now     = group_len_ff;
         starts_now        = 1'b0;
         len_now           = group_len_ff;
      end else begin
         counter_now       = counter_ff + IDX_ONE;
         trailers_left_now = 2'd0;
         group_len_now     = LEN_ONE;
         starts_now        = 1'b1;
         len_now           = LEN_ONE;
      end
   end

   always_comb begin
      start_in         = start_ff;
      counter_in       = counter_ff;
      trailers_left_in = trailers_left_ff;
      group_len_in     = group_len_ff;
      if (take) begin
         if (pop_job.last) begin
            // stream done: next stream numbers from start again
            counter_in       = INDEX_WIDTH'(start_ff) - IDX_ONE;
            trailers_left_in = 2'd0;
            group_len_in     = LEN_ONE;
         end else begin
            counter_in       = counter_now;
            trailers_left_in = trailers_left_now;
            group_len_in     = group_len_now;
         end
      end
      if (csr_wr_en) begin
         start_in   = csr_wr_data;
         counter_in = INDEX_WIDTH'(csr_wr_data) - IDX_ONE;
      end
      if (take)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff         <= 32'd0;
         counter_ff       <= '1;
         trailers_left_ff <= 2'd0;
         group_len_ff     <= LEN_ONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         start_ff         <= start_in;
         counter_ff       <= counter_in;
         trailers_left_ff <= trailers_left_in;
         group_len_ff     <= group_len_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff    <= pop_job.data;
         char_index_ff  <= 32'(counter_now);
         starts_char_ff <= starts_now;
         char_len_ff    <= len_now;
         last_ff        <= pop_job.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_char_index  = char_index_ff;
   assign rsp_starts_char = starts_char_ff;
   assign rsp_char_len    = char_len_ff;
   assign rsp_last        = last_ff;

   a_open_group: assert property (@(posedge clock) disable iff (reset)
      trailers_left_ff < group_len_ff)
      else $error("trailer count not below group length");

   a_cont_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !starts_char_ff |-> char_len_ff >= 3'd2 && char_len_ff <= 3'd4)
      else $error("continuation byte outside a multi-byte group");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      take && pop_job.last |=> trailers_left_ff == 2'd0 && group_len_ff == LEN_ONE)
      else $error("group state not cleared at end of stream");

endmodule

`default_nettype wire

// File: sv/utf8_char_position_tracker_core.sv
// UTF-8 character position tracker, top level.
// Instantiates u8cpt_front, u8cpt_queue and u8cpt_back; uses u8cpt_pkg.
//
// Usage:
//  - req_* : byte stream, valid/ready. req_end_of_stream marks the final byte.
//  - rsp_* : one word per input byte, in order, with the character index,
//    start-of-character flag, character length and a last flag.
//  - csr_* : start_index register, written with csr_wr_en; also restarts the
//    numbering. Write only while the block is idle.
// A byte is reported once three later bytes have arrived; its job then passes
// a queue entry and the output register on its way to rsp. Throughput: one
// byte per cycle in steady state while rsp_ready holds, set by the single job
// path front -> queue -> back. A final byte drains the window: held bytes plus
// the final one leave one per cycle while the queue has room, with req_ready low.
// Reset clears the window, queue, and group state and sets start_index to 0.
// A stalled receiver fills the output register and the two-entry queue,
// after which req_ready drops as soon as the window is full.
`timescale 1ns / 1ps
`default_nettype none

module utf8_char_position_tracker_core import u8cpt_pkg::*; #(
   parameter int INDEX_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic [31:0]      rsp_char_index,
   output logic             rsp_starts_char,
   output logic [2:0]       rsp_char_len,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   // front -> queue
   logic    push_valid, push_ready;
   job_type push_job;
   // queue -> back
   logic    pop_valid, pop_ready;
   job_type pop_job;

   u8cpt_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_job          (push_job)
   );

   u8cpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // counter width follows INDEX_WIDTH; rsp_char_index shows its low 32 bits
   u8cpt_back #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_job         (pop_job),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_char_index  (rsp_char_index),
      .rsp_starts_char (rsp_starts_char),
      .rsp_char_len    (rsp_char_len),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for utf8_char_position_tracker_core: byte streams in, one word per byte out.
// Depends on u8cpt_pkg and the core RTL. A built-in character tracker predicts every word.
`timescale 1ns / 1ps

module tb;
   import u8cpt_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] char_index;
      logic        starts_char;
      logic [2:0]  char_len;
      logic        last;
   } char_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [31:0] rsp_char_index;
   logic        rsp_starts_char;
   logic [2:0]  rsp_char_len;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'h0;

   // tracker state, mirrors the block
   logic [7:0]  held_bytes [0:2] = '{8'h00, 8'h00, 8'h00};
   int unsigned held_fill = 0;
   int unsigned trailers_due = 0;
   logic [2:0]  open_len = LEN_ONE;
   logic [31:0] base_index = 32'h0;
   logic [31:0] char_count = 32'hFFFF_FFFF;

   char_word_type pending_words [$];

   int unsigned send_idle_pct = 0;
   int unsigned ready_stall_pct = 0;
   int unsigned hold_left = 0;
   int unsigned fail_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned streams_sent = 0;
   int unsigned words_checked = 0;
   int unsigned cycle_count = 0;

   utf8_char_position_tracker_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_char_index    (rsp_char_index),
      .rsp_starts_char   (rsp_starts_char),
      .rsp_char_len      (rsp_char_len),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= ready_stall_pct);
      end
   end

   always @(posedge clock) begin : check_words
      char_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: out_byte %0h char_index %0h", rsp_out_byte, rsp_char_index);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_char_index !== want.char_index) begin
               $error("char_index: expected %0h, got %0h", want.char_index, rsp_char_index);
               fail_count++;
            end
            if (rsp_starts_char !== want.starts_char) begin
               $error("starts_char: expected %0d, got %0d", want.starts_char, rsp_starts_char);
               fail_count++;
            end
            if (rsp_char_len !== want.char_len) begin
               $error("char_len: expected %0d, got %0d", want.char_len, rsp_char_len);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // classify seq[pos]; seq[pos+1 .. n-1] is the lookahead still inside the stream
   function automatic void track_byte(input logic [7:0] seq [0:3], input int unsigned pos,
                                      input int unsigned n, input logic is_last);
      logic [7:0]    b;
      logic [2:0]    want_len;
      logic          complete;
      int unsigned   k;
      char_word_type w;
      b = seq[pos];
      want_len = LEN_NONE;
      if ((b & LEAD2_MASK) == LEAD2_CODE) want_len = 3'd2;
      else if ((b & LEAD3_MASK) == LEAD3_CODE) want_len = 3'd3;
      else if ((b & LEAD4_MASK) == LEAD4_CODE) want_len = 3'd4;
      w.out_byte    = b;
      w.starts_char = 1'b1;
      w.char_len    = LEN_ONE;
      w.last        = is_last;
      if (want_len != LEN_NONE) begin
         complete = 1'b1;
         for (k = 1; k < want_len; k++)
            if (pos + k >= n || (seq[pos + k] & TRAIL_MASK) != TRAIL_CODE) complete = 1'b0;
         if (!complete) want_len = LEN_ONE;
         char_count++;
         trailers_due = want_len - 1;
         open_len = want_len;
         w.char_len = want_len;
      end else if ((b & TRAIL_MASK) == TRAIL_CODE && trailers_due != 0) begin
         trailers_due--;
         w.starts_char = 1'b0;
         w.char_len = open_len;
      end else begin
         // lone byte: single, orphan trailer or invalid
         char_count++;
         trailers_due = 0;
         open_len = LEN_ONE;
      end
      w.char_index = char_count;
      pending_words.push_back(w);
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic eos);
      logic [7:0]  seq [0:3];
      int unsigned i;
      int unsigned n;
      for (i = 0; i < 3; i++) seq[i] = held_bytes[i];
      if (!eos) begin
         if (held_fill < 3) begin
            held_bytes[held_fill] = b;
            held_fill++;
         end else begin
            seq[3] = b;
            track_byte(seq, 0, 4, 1'b0);
            held_bytes[0] = seq[1];
            held_bytes[1] = seq[2];
            held_bytes[2] = seq[3];
         end
      end else begin
         // flush: everything held plus the final byte, lookahead cut at the end
         seq[held_fill] = b;
         n = held_fill + 1;
         for (i = 0; i < n; i++) track_byte(seq, i, n, (i + 1 == n));
         held_fill = 0;
         trailers_due = 0;
         open_len = LEN_ONE;
         char_count = base_index - 1;
      end
   endfunction

   function automatic logic [7:0] rand_trailer();
      return {2'b10, 6'($urandom)};
   endfunction

   // valid stays high between back-to-back bytes; it drops for an idle gap or in drain_words
   task automatic send_byte(input logic [7:0] b, input logic eos);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
      predict_byte(b, eos);
      bytes_sent++;
   endtask

   task automatic send_stream(input logic [7:0] bytes [$]);
      int unsigned i;
      for (i = 0; i < bytes.size(); i++) send_byte(bytes[i], (i + 1 == bytes.size()));
      streams_sent++;
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_start_index(input logic [31:0] value);
      drain_words();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_index = value;
      char_count = value - 1;
   endtask

   // mostly well-formed characters with random payload, some broken or noise
   task automatic send_random_stream(input int unsigned n_chars);
      logic [7:0]  bytes [$];
      int unsigned i;
      for (i = 0; i < n_chars; i++) begin
         case ($urandom_range(9))
            0, 1, 2: bytes.push_back({1'b0, 7'($urandom)});
            3, 4: begin
               bytes.push_back({3'b110, 5'($urandom)});
               bytes.push_back(rand_trailer());
            end
            5: begin
               bytes.push_back({4'b1110, 4'($urandom)});
               bytes.push_back(rand_trailer());
               bytes.push_back(rand_trailer());
            end
            6: begin
               bytes.push_back({5'b11110, 3'($urandom)});
               repeat (3) bytes.push_back(rand_trailer());
            end
            7: begin
               // lead cut short by a non-trailer
               bytes.push_back({5'b11110, 3'($urandom)});
               repeat ($urandom_range(2)) bytes.push_back(rand_trailer());
               bytes.push_back({1'b0, 7'($urandom)});
            end
            8: bytes.push_back(rand_trailer());
            default: bytes.push_back(8'($urandom));
         endcase
      end
      send_stream(bytes);
   endtask

   task automatic test_valid_chars();
      write_start_index(32'd0);
      send_stream('{8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                    8'hF8, 8'h7F});
   endtask

   task automatic test_lone_bytes();
      write_start_index(32'd1000);
      send_stream('{8'hFF});
      // orphan trailer, lead broken by a single, four-byte lead cut by stream end
      send_stream('{8'h80, 8'hC0, 8'h41, 8'hF7, 8'hBF, 8'hBF});
   endtask

   task automatic test_index_wrap();
      write_start_index(32'hFFFF_FFFF);
      send_stream('{8'h00, 8'hE0, 8'h80, 8'hBF});
   endtask

   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned target;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               ready_stall_pct = 0;
               write_start_index(32'hFFFF_FFFE);
            end
            1: begin
               send_idle_pct = 60;
               ready_stall_pct = 0;
               write_start_index($urandom);
            end
            2: begin
               send_idle_pct = 0;
               ready_stall_pct = 60;
               write_start_index(32'd0);
            end
            default: begin
               send_idle_pct = 36;
               ready_stall_pct = 36;
               write_start_index($urandom);
            end
         endcase
         target = bytes_sent + 15;
         while (bytes_sent < target) send_random_stream($urandom_range(1, 6));
      end
   endtask

   task automatic test_backpressure();
      drain_words();
      send_idle_pct = 0;
      ready_stall_pct = 0;
      hold_left <= 80;
      send_random_stream(12);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_valid_chars();
      test_lone_bytes();
      test_index_wrap();
      test_random_traffic();
      test_backpressure();
      drain_words();
      $display("Sent %0d bytes in %0d streams, checked %0d words.",
               bytes_sent, streams_sent, words_checked);
      $display("Covered byte classes, index wrap, four idle mixes and a long receiver hold-off.");
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
sv/u8cpt_pkg.sv
sv/u8cpt_front.sv
sv/u8cpt_queue.sv
sv/u8cpt_back.sv
sv/utf8_char_position_tracker_core.sv
tb/tb.sv
